// File: hdl/srct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srct_pkg
// shared widths, walk phases and controller/datapath interface types
// ----------------------------------------------------------------------------
package srct_pkg;

   localparam int COORD_BITS = 22;
   localparam int SCALE_BITS = 10;
   localparam int CNT_BITS   = $clog2(COORD_BITS + 1);
   localparam int DELTA_BITS = COORD_BITS + 1;
   localparam int MUL_BITS   = SCALE_BITS + 1;
   localparam int DEN_BITS   = MUL_BITS + DELTA_BITS;
   localparam int PROD_BITS  = DEN_BITS + 1;
   localparam int ACC_BITS   = 40;
   localparam int CELL_BITS  = 2 * COORD_BITS;

   localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(1000);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_VERT,
      PH_TOP,
      PH_INNER,
      PH_TAIL_TOP,
      PH_TAIL_INNER
   } phase_type;

   typedef struct packed {
      logic load;
      logic init1;
      logic init2;
      logic step;
      logic emit_zero;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic active;
      logic hit;
      logic stop;
   } status_type;

endpackage

// File: hdl/srct_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srct_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module srct_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [srct_pkg::COORD_BITS-1:0]     dividend,
   input  logic [srct_pkg::SCALE_BITS-1:0]     divisor,
   output logic [srct_pkg::COORD_BITS-1:0]     quotient,
   output logic [srct_pkg::SCALE_BITS-1:0]     remainder,
   output logic                                done
);

   logic [srct_pkg::CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [srct_pkg::COORD_BITS-1:0] dvd_ff, dvd_in;
   logic [srct_pkg::SCALE_BITS-1:0] rem_ff, rem_in, div_ff, div_in;
   logic [srct_pkg::SCALE_BITS:0]   trial;
   logic                            ge;

   always_comb begin
      trial  = {rem_ff, dvd_ff[srct_pkg::COORD_BITS-1]};
      ge     = trial >= {1'b0, div_ff};
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      if (start) begin
         cnt_in = srct_pkg::CNT_BITS'(srct_pkg::COORD_BITS);
         dvd_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         dvd_in = {dvd_ff[srct_pkg::COORD_BITS-2:0], ge};
         rem_in = ge ? srct_pkg::SCALE_BITS'(trial - {1'b0, div_ff})
                     : trial[srct_pkg::SCALE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient  = dvd_ff;
   assign remainder = rem_ff;
   assign done      = cnt_ff == '0;

endmodule

// File: hdl/srct_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srct_ctrl
// sequencer for load, setup and cell walk transactions
// ----------------------------------------------------------------------------
module srct_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_mode,
   input  logic                 slot_free,
   output logic                 req_tready,
   output srct_pkg::cmd_type    cmd,
   input  srct_pkg::status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_INIT1,
      ST_INIT2,
      ST_WALK
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_mode) begin
                  cmd.load = 1'b1;
                  state_in = ST_DIV;
               end else if (status.active) begin
                  state_in = ST_WALK;
               end else begin
                  cmd.emit_zero = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_INIT1;
            end
         end
         ST_INIT1: begin
            cmd.init1 = 1'b1;
            state_in  = ST_INIT2;
         end
         ST_INIT2: begin
            cmd.init2 = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (status.hit) begin
               state_in = ST_IDLE;
            end else if (status.stop) begin
               cmd.emit_zero = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/srct_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srct_dp
// scale register, dividers, accumulator walk and result register
// ----------------------------------------------------------------------------
module srct_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [srct_pkg::SCALE_BITS-1:0]     csr_wr_data,
   input  logic [srct_pkg::COORD_BITS-1:0]     begin_x,
   input  logic [srct_pkg::COORD_BITS-1:0]     begin_y,
   input  logic [srct_pkg::COORD_BITS-1:0]     end_x,
   input  logic [srct_pkg::COORD_BITS-1:0]     end_y,
   input  srct_pkg::cmd_type                   cmd,
   output srct_pkg::status_type                status,
   input  logic                                rsp_tready,
   output logic                                rsp_valid,
   output logic [srct_pkg::COORD_BITS-1:0]     rsp_cell_x,
   output logic [srct_pkg::COORD_BITS-1:0]     rsp_cell_y,
   output logic                                rsp_valid_res,
   output logic                                rsp_last
);

   localparam int CB = srct_pkg::COORD_BITS;
   localparam int SB = srct_pkg::SCALE_BITS;
   localparam int AB = srct_pkg::ACC_BITS;
   localparam int DB = srct_pkg::DEN_BITS;
   localparam int PB = srct_pkg::PROD_BITS;
   localparam int MB = srct_pkg::MUL_BITS;
   localparam int XB = srct_pkg::DELTA_BITS;

   logic [SB-1:0] csr_ff, scale_ff, scale_in, scale_eff;
   logic          swap;
   logic [CB-1:0] sbx, sby, sex, sey;
   logic [CB-1:0] qbx, qby, qex, qey;
   logic [SB-1:0] rbx, rby, rex, rey;
   logic          dbx, dby, dex, dey;

   logic        [XB-1:0] dx_ff, dx_in;
   logic signed [XB-1:0] dy_ff, dy_in;
   logic        [DB-1:0] denom_ff, denom_in, p1_ff, p1_in;
   logic signed [PB-1:0] p2_ff, p2_in, step_ff, step_in, tail_ff, tail_in;
   logic signed [AB-1:0] acc_ff, acc_in, acc_adj, den_ext;
   logic        [CB-1:0] cx_ff, cx_in, fx_ff, fx_in, vend_ff, vend_in, cx_inc, ymin, ymax;
   logic        [CB:0]   cy_ff, cy_in, cy_adj;
   logic        [srct_pkg::CELL_BITS-1:0] le_ff, le_in, cand;
   srct_pkg::phase_type  phase_ff, phase_in;
   logic        [MB-1:0] two_s, k_bx, tspan;

   logic          valid_ff, valid_in, vres_ff, vres_in, last_ff, last_in, emit, is_last;
   logic [CB-1:0] ocx_ff, ocx_in, ocy_ff, ocy_in;
   logic          asc, cond, hit, stop;

   assign scale_eff = (csr_ff == '0) ? SB'(1) : csr_ff;
   assign swap      = begin_x > end_x;
   assign sbx       = swap ? end_x   : begin_x;
   assign sby       = swap ? end_y   : begin_y;
   assign sex       = swap ? begin_x : end_x;
   assign sey       = swap ? begin_y : end_y;

   srct_div u_div_bx (.clock, .reset, .start(cmd.load), .dividend(sbx), .divisor(scale_eff),
                      .quotient(qbx), .remainder(rbx), .done(dbx));
   srct_div u_div_by (.clock, .reset, .start(cmd.load), .dividend(sby), .divisor(scale_eff),
                      .quotient(qby), .remainder(rby), .done(dby));
   srct_div u_div_ex (.clock, .reset, .start(cmd.load), .dividend(sex), .divisor(scale_eff),
                      .quotient(qex), .remainder(rex), .done(dex));
   srct_div u_div_ey (.clock, .reset, .start(cmd.load), .dividend(sey), .divisor(scale_eff),
                      .quotient(qey), .remainder(rey), .done(dey));

   assign two_s   = {scale_ff, 1'b0};
   assign k_bx    = two_s - {rbx, 1'b0} - MB'(1);
   assign tspan   = {rex, 1'b1};
   assign asc     = dy_ff > 0;
   assign den_ext = $signed({{(AB-DB){1'b0}}, denom_ff});
   assign ymin    = (qby < qey) ? qby : qey;
   assign ymax    = (qby < qey) ? qey : qby;
   assign cx_inc  = cx_ff + 1'b1;

   always_comb begin
      scale_in = scale_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      denom_in = denom_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      step_in  = step_ff;
      tail_in  = tail_ff;
      acc_in   = acc_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      fx_in    = fx_ff;
      vend_in  = vend_ff;
      le_in    = le_ff;
      phase_in = phase_ff;
      acc_adj  = acc_ff;
      cy_adj   = cy_ff;
      cand     = {cx_ff, cy_ff[CB-1:0]};
      cond     = 1'b0;
      hit      = 1'b0;
      stop     = 1'b0;
      emit     = 1'b0;

      if (cmd.load) begin
         scale_in = scale_eff;
         dx_in    = XB'(sex) - XB'(sbx);
         dy_in    = $signed(XB'(sey) - XB'(sby));
      end

      if (cmd.init1) begin
         denom_in = DB'(two_s * dx_ff);
         p1_in    = DB'({rby, 1'b1} * dx_ff);
         p2_in    = dy_ff * $signed({1'b0, k_bx});
         step_in  = dy_ff * $signed({1'b0, two_s});
         tail_in  = dy_ff * $signed({1'b0, tspan});
      end

      if (cmd.init2) begin
         fx_in = qex;
         cx_in = qbx;
         emit  = 1'b1;
         if (qbx == qex) begin
            vend_in  = ymax;
            le_in    = {qbx, ymin};
            cy_in    = {1'b0, ymin} + 1'b1;
            phase_in = srct_pkg::PH_VERT;
         end else begin
            vend_in  = qey;
            le_in    = {qbx, qby};
            cy_in    = {1'b0, qby};
            acc_in   = AB'(p1_ff) + AB'(p2_ff);
            phase_in = srct_pkg::PH_TOP;
         end
      end

      if (cmd.step) begin
         unique case (phase_ff)
            srct_pkg::PH_VERT: begin
               if (cy_ff > {1'b0, vend_ff}) begin
                  phase_in = srct_pkg::PH_IDLE;
                  stop     = 1'b1;
               end else begin
                  hit   = cand != le_ff;
                  cy_in = cy_ff + 1'b1;
               end
            end
            srct_pkg::PH_TOP: begin
               phase_in = srct_pkg::PH_INNER;
               hit      = cand != le_ff;
            end
            srct_pkg::PH_TAIL_TOP: begin
               phase_in = srct_pkg::PH_TAIL_INNER;
               hit      = cand != le_ff;
            end
            srct_pkg::PH_INNER, srct_pkg::PH_TAIL_INNER: begin
               cond = asc ? (acc_ff > den_ext) : (acc_ff < 0);
               if (cond) begin
                  acc_in = asc ? acc_ff - den_ext : acc_ff + den_ext;
                  cy_in  = asc ? cy_ff + 1'b1 : cy_ff - 1'b1;
                  cand   = {cx_ff, cy_in[CB-1:0]};
                  hit    = cand != le_ff;
               end else if (phase_ff == srct_pkg::PH_TAIL_INNER) begin
                  phase_in = srct_pkg::PH_IDLE;
                  stop     = 1'b1;
               end else begin
                  cx_in = cx_inc;
                  if (asc && acc_ff == den_ext) begin
                     acc_adj = acc_ff - den_ext;
                     cy_adj  = cy_ff + 1'b1;
                  end else if (!asc && acc_ff == 0) begin
                     acc_adj = acc_ff + den_ext;
                     cy_adj  = cy_ff - 1'b1;
                  end
                  cy_in = cy_adj;
                  if (cx_inc == fx_ff) begin
                     acc_in   = acc_adj + AB'(tail_ff);
                     phase_in = srct_pkg::PH_TAIL_TOP;
                  end else begin
                     acc_in   = acc_adj + AB'(step_ff);
                     phase_in = srct_pkg::PH_TOP;
                  end
               end
            end
            default: begin
               phase_in = srct_pkg::PH_IDLE;
               stop     = 1'b1;
            end
         endcase
         if (hit) begin
            le_in = cand;
            emit  = 1'b1;
         end
      end

      is_last = le_in == {fx_in, vend_in};
      if (emit && is_last) begin
         phase_in = srct_pkg::PH_IDLE;
      end
   end

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      ocx_in   = ocx_ff;
      ocy_in   = ocy_ff;
      vres_in  = vres_ff;
      last_in  = last_ff;
      if (emit) begin
         valid_in = 1'b1;
         ocx_in   = le_in[srct_pkg::CELL_BITS-1:CB];
         ocy_in   = le_in[CB-1:0];
         vres_in  = 1'b1;
         last_in  = is_last;
      end else if (cmd.emit_zero) begin
         valid_in = 1'b1;
         ocx_in   = '0;
         ocy_in   = '0;
         vres_in  = 1'b0;
         last_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff   <= srct_pkg::SCALE_RESET;
         phase_ff <= srct_pkg::PH_IDLE;
         valid_ff <= 1'b0;
         le_ff    <= '0;
         cx_ff    <= '0;
         cy_ff    <= '0;
         fx_ff    <= '0;
         vend_ff  <= '0;
         acc_ff   <= '0;
         dy_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
         phase_ff <= phase_in;
         valid_ff <= valid_in;
         le_ff    <= le_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         fx_ff    <= fx_in;
         vend_ff  <= vend_in;
         acc_ff   <= acc_in;
         dy_ff    <= dy_in;
      end
      scale_ff <= scale_in;
      dx_ff    <= dx_in;
      denom_ff <= denom_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      step_ff  <= step_in;
      tail_ff  <= tail_in;
      ocx_ff   <= ocx_in;
      ocy_ff   <= ocy_in;
      vres_ff  <= vres_in;
      last_ff  <= last_in;
   end

   assign status.div_done = dbx && dby && dex && dey;
   assign status.active   = phase_ff != srct_pkg::PH_IDLE;
   assign status.hit      = hit;
   assign status.stop     = stop;

   assign rsp_valid     = valid_ff;
   assign rsp_cell_x    = ocx_ff;
   assign rsp_cell_y    = ocy_ff;
   assign rsp_valid_res = vres_ff;
   assign rsp_last      = last_ff;

endmodule

// File: hdl/subpixel_ray_cell_traversal_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subpixel_ray_cell_traversal_unit
// lists every grid cell touched by a segment given in subpixel units
//
//   port group  direction  contents
//   req_*       in         mode, begin/end coordinates
//   rsp_*       out        cell x/y, valid flag, last
//   csr_*       in         cell scale in subpixel units
//
// load transaction: the 22-step divide by the scale, then init1 and init2 setup
// next transaction: empty result if no active ray, else walk steps, one per cycle
// reset clears the walk, scale returns to 1000
// a result waits in the output register; no new transaction until it drains
// ----------------------------------------------------------------------------
module subpixel_ray_cell_traversal_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // begin_x, begin_y, end_x, end_y
   input  logic [0:0]  req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // cell_x, cell_y, zero pad
   output logic [0:0]  rsp_tuser,   // valid_res
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [9:0]  csr_wr_data
);

   srct_pkg::cmd_type    cmd;
   srct_pkg::status_type status;
   logic                 slot_free;
   logic [21:0]          cell_x, cell_y;

   assign slot_free = !(rsp_tvalid && !rsp_tready);

   srct_ctrl u_ctrl (
      .clock,
      .reset,
      .req_tvalid,
      .req_mode  (req_tuser[0]),
      .slot_free,
      .req_tready,
      .cmd,
      .status
   );

   srct_dp u_dp (
      .clock,
      .reset,
      .csr_wr_en,
      .csr_wr_data,
      .begin_x      (req_tdata[21:0]),
      .begin_y      (req_tdata[43:22]),
      .end_x        (req_tdata[65:44]),
      .end_y        (req_tdata[87:66]),
      .cmd,
      .status,
      .rsp_tready,
      .rsp_valid    (rsp_tvalid),
      .rsp_cell_x   (cell_x),
      .rsp_cell_y   (cell_y),
      .rsp_valid_res(rsp_tuser[0]),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {4'b0, cell_y, cell_x};

   a_ready_slot: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> slot_free)
      else $error("transaction accepted while result blocked");

   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0])
      else $error("last flag on empty result");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("empty result carries a cell");

   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser[0] |=> !req_tready)
      else $error("ready during load setup");

endmodule

// File: sim/tb_subpixel_ray_cell_traversal_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_subpixel_ray_cell_traversal_unit
// self-checking bench for the subpixel ray cell traversal unit
//
// a directed table covers reset state, extreme coordinates, vertical and
// diagonal rays, exhaustion and reload during a ray; random rays with
// random pulls follow, at several scales including zero and extreme ones.
// every result is compared with a cell walk predicted in the bench, with
// random idling on both stream sides
// ----------------------------------------------------------------------------
module tb_subpixel_ray_cell_traversal_unit;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_NEXT = 1'b1;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [srct_pkg::COORD_BITS-1:0] cx;
      logic [srct_pkg::COORD_BITS-1:0] cy;
      logic                            vld;
      logic                            lst;
   } cell_rsp_type;

   typedef struct {
      logic                            mode;
      logic [srct_pkg::COORD_BITS-1:0] bx, by, ex, ey;
      logic                            known;
      cell_rsp_type                    rsp;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [9:0]  csr_wr_data = '0;

   subpixel_ray_cell_traversal_unit uut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // predicted walk state
   logic [srct_pkg::SCALE_BITS-1:0] w_scale_reg;
   longint w_cx, w_cy, w_fx, w_vey, w_acc, w_dx, w_dy, w_den, w_tail, w_rs;
   logic [srct_pkg::CELL_BITS-1:0] w_last;
   srct_pkg::phase_type w_ph;

   cell_rsp_type expected_cells[$];
   int  err_count = 0;
   int  cycle_count = 0;
   bit  run_done = 0;

   function automatic logic [srct_pkg::CELL_BITS-1:0] cell_key(longint x, longint y);
      return {x[srct_pkg::COORD_BITS-1:0], y[srct_pkg::COORD_BITS-1:0]};
   endfunction

   function automatic bit offer_cell();
      logic [srct_pkg::CELL_BITS-1:0] c;
      c = cell_key(w_cx, w_cy);
      if (c == w_last) return 0;
      w_last = c;
      return 1;
   endfunction

   function automatic bit walk_next();
      bit asc;
      asc = w_dy > 0;
      forever begin
         unique case (w_ph)
            srct_pkg::PH_VERT: begin
               if (w_cy > w_vey) begin
                  w_ph = srct_pkg::PH_IDLE;
                  return 0;
               end
               if (offer_cell()) begin
                  w_cy++;
                  return 1;
               end
               w_cy++;
            end
            srct_pkg::PH_TOP, srct_pkg::PH_TAIL_TOP: begin
               w_ph = (w_ph == srct_pkg::PH_TOP) ? srct_pkg::PH_INNER
                                                 : srct_pkg::PH_TAIL_INNER;
               if (offer_cell()) return 1;
            end
            srct_pkg::PH_INNER, srct_pkg::PH_TAIL_INNER: begin
               if (asc ? (w_acc > w_den) : (w_acc < 0)) begin
                  if (asc) begin
                     w_acc -= w_den;
                     w_cy++;
                  end else begin
                     w_acc += w_den;
                     w_cy--;
                  end
                  if (offer_cell()) return 1;
               end else if (w_ph == srct_pkg::PH_TAIL_INNER) begin
                  w_ph = srct_pkg::PH_IDLE;
                  return 0;
               end else begin
                  w_cx++;
                  if (asc && w_acc == w_den) begin
                     w_acc -= w_den;
                     w_cy++;
                  end
                  if (!asc && w_acc == 0) begin
                     w_acc += w_den;
                     w_cy--;
                  end
                  if (w_cx == w_fx) begin
                     w_acc += w_dy * w_tail;
                     w_ph = srct_pkg::PH_TAIL_TOP;
                  end else begin
                     w_acc += w_dy * 2 * w_rs;
                     w_ph = srct_pkg::PH_TOP;
                  end
               end
            end
            default: begin
               w_ph = srct_pkg::PH_IDLE;
               return 0;
            end
         endcase
      end
   endfunction

   function automatic void load_ray(longint bx, longint by, longint ex, longint ey);
      longint s, t;
      s = w_scale_reg;
      if (s == 0) s = 1;
      w_rs = s;
      if (bx > ex) begin
         t = bx; bx = ex; ex = t;
         t = by; by = ey; ey = t;
      end
      w_fx = ex / s;
      if (bx / s == ex / s) begin
         w_cx = bx / s;
         w_cy = ((by < ey) ? by : ey) / s;
         w_vey = ((by > ey) ? by : ey) / s;
         w_last = cell_key(w_cx, w_cy);
         w_cy++;
         w_ph = srct_pkg::PH_VERT;
         return;
      end
      w_dx = ex - bx;
      w_dy = ey - by;
      w_den = 2 * s * w_dx;
      w_cx = bx / s;
      w_cy = by / s;
      w_vey = ey / s;
      w_last = cell_key(w_cx, w_cy);
      w_acc = (2 * (by % s) + 1) * w_dx + w_dy * (2 * s - 2 * (bx % s) - 1);
      w_tail = 2 * (ex % s) + 1;
      w_ph = srct_pkg::PH_TOP;
   endfunction

   function automatic cell_rsp_type predict_cell(logic mode,
         logic [srct_pkg::COORD_BITS-1:0] bx, logic [srct_pkg::COORD_BITS-1:0] by,
         logic [srct_pkg::COORD_BITS-1:0] ex, logic [srct_pkg::COORD_BITS-1:0] ey);
      cell_rsp_type r;
      bit got;
      r = '0;
      if (mode == MODE_LOAD) begin
         load_ray(bx, by, ex, ey);
         got = 1;
      end else if (w_ph == srct_pkg::PH_IDLE) begin
         got = 0;
      end else begin
         got = walk_next();
      end
      if (got) begin
         r.cx = w_last[srct_pkg::CELL_BITS-1:srct_pkg::COORD_BITS];
         r.cy = w_last[srct_pkg::COORD_BITS-1:0];
         r.vld = 1'b1;
         r.lst = (w_last == cell_key(w_fx, w_vey));
         if (r.lst) w_ph = srct_pkg::PH_IDLE;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint exp_v);
      $display("mismatch %s: got %0d expected %0d", what, got, exp_v);
      err_count++;
   endtask

   // response side
   int rsp_wait = 0;
   always @(posedge clock) begin
      cell_rsp_type e;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_cells.size() == 0) begin
            report_mismatch("unexpected transaction", 0, 0);
         end else begin
            e = expected_cells.pop_front();
            if (rsp_tdata[srct_pkg::COORD_BITS-1:0] !== e.cx)
               report_mismatch("cell_x", rsp_tdata[srct_pkg::COORD_BITS-1:0], e.cx);
            if (rsp_tdata[2*srct_pkg::COORD_BITS-1:srct_pkg::COORD_BITS] !== e.cy)
               report_mismatch("cell_y",
                               rsp_tdata[2*srct_pkg::COORD_BITS-1:srct_pkg::COORD_BITS],
                               e.cy);
            if (rsp_tuser[0] !== e.vld) report_mismatch("valid_res", rsp_tuser[0], e.vld);
            if (rsp_tlast !== e.lst) report_mismatch("last", rsp_tlast, e.lst);
         end
      end
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         rsp_tready <= (rsp_wait == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_tready <= (rsp_wait == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout");
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_item(logic mode, logic [srct_pkg::COORD_BITS-1:0] bx,
         logic [srct_pkg::COORD_BITS-1:0] by, logic [srct_pkg::COORD_BITS-1:0] ex,
         logic [srct_pkg::COORD_BITS-1:0] ey, bit known, cell_rsp_type rsp);
      int gap;
      cell_rsp_type p;
      p = predict_cell(mode, bx, by, ex, ey);
      if (known && p !== rsp) report_mismatch("table row", p, rsp);
      req_tdata <= {ey, ex, by, bx};
      req_tuser <= mode;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_cells.insert(expected_cells.size(), p);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_all();
      req_tvalid <= 1'b0;
      while (expected_cells.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_scale(logic [srct_pkg::SCALE_BITS-1:0] v);
      drain_all();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      w_scale_reg = v;
   endtask

   function automatic logic [srct_pkg::COORD_BITS-1:0] rnd_coord(
         logic [srct_pkg::COORD_BITS-1:0] base, int span);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return srct_pkg::COORD_BITS'($urandom);
      if (sel == 1) return srct_pkg::COORD_BITS'(32'hffffffff - $urandom_range(0, span));
      if (sel == 2) return srct_pkg::COORD_BITS'($urandom_range(0, span));
      return srct_pkg::COORD_BITS'(base + $urandom_range(0, span) - span / 2);
   endfunction

   stim_row_type table_rows[$];

   function automatic void add_row(logic mode, int bx, int by, int ex, int ey, bit known,
         int cx, int cy, bit v, bit l);
      stim_row_type r;
      r.mode = mode;
      r.bx = srct_pkg::COORD_BITS'(bx);
      r.by = srct_pkg::COORD_BITS'(by);
      r.ex = srct_pkg::COORD_BITS'(ex);
      r.ey = srct_pkg::COORD_BITS'(ey);
      r.known = known;
      r.rsp.cx = srct_pkg::COORD_BITS'(cx);
      r.rsp.cy = srct_pkg::COORD_BITS'(cy);
      r.rsp.vld = v;
      r.rsp.lst = l;
      table_rows.insert(table_rows.size(), r);
   endfunction

   initial begin
      logic [srct_pkg::COORD_BITS-1:0] bx, by, ex, ey;
      int pulls;
      int scales[6];
      scales = '{1000, 0, 1, 1023, 7, 64};
      w_scale_reg = srct_pkg::SCALE_RESET;
      w_cx = 0; w_cy = 0; w_fx = 0; w_vey = 0; w_acc = 0; w_dx = 0; w_dy = 0;
      w_den = 0; w_tail = 0; w_rs = 1; w_last = '0; w_ph = srct_pkg::PH_IDLE;

      add_row(MODE_NEXT, 0, 0, 0, 0, 1, 0, 0, 0, 0);
      add_row(MODE_LOAD, 0, 0, 0, 0, 1, 0, 0, 1, 1);
      add_row(MODE_NEXT, 0, 0, 0, 0, 1, 0, 0, 0, 0);
      add_row(MODE_LOAD, 500, 100, 500, 3200, 1, 0, 0, 1, 0);
      for (int i = 0; i < 4; i++) add_row(MODE_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(MODE_LOAD, 4999, 2500, 100, 100, 0, 0, 0, 0, 0);
      for (int i = 0; i < 8; i++) add_row(MODE_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(MODE_LOAD, 100, 3900, 3100, 50, 0, 0, 0, 0, 0);
      add_row(MODE_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(MODE_LOAD, 4194303, 4194303, 4194303, 4194303, 1, 4194, 4194, 1, 1);
      add_row(MODE_LOAD, 4194303, 0, 4190000, 4194303, 0, 0, 0, 0, 0);
      for (int i = 0; i < 5; i++) add_row(MODE_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i])
         send_item(table_rows[i].mode, table_rows[i].bx, table_rows[i].by, table_rows[i].ex,
                   table_rows[i].ey, table_rows[i].known, table_rows[i].rsp);

      for (int ph = 0; ph < 6; ph++) begin
         write_scale(srct_pkg::SCALE_BITS'(scales[ph]));
         for (int n = 0; n < 14; n++) begin
            int span;
            span = (scales[ph] <= 1) ? 12 : scales[ph] * $urandom_range(1, 6);
            bx = srct_pkg::COORD_BITS'($urandom);
            by = srct_pkg::COORD_BITS'($urandom);
            ex = rnd_coord(bx, span);
            ey = rnd_coord(by, span);
            if ($urandom_range(0, 4) == 0) ex = bx;
            send_item(MODE_LOAD, bx, by, ex, ey, 0, '0);
            pulls = $urandom_range(0, 16);
            if ($urandom_range(0, 7) == 0) pulls = 1;
            for (int k = 0; k < pulls; k++)
               send_item(MODE_NEXT, srct_pkg::COORD_BITS'($urandom),
                         srct_pkg::COORD_BITS'($urandom), srct_pkg::COORD_BITS'($urandom),
                         srct_pkg::COORD_BITS'($urandom), 0, '0);
         end
         if (ph == 2) drain_all();
      end

      drain_all();
      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
